### src/pttd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pttd_pkg - shared types and constants of the pan/tilt command decoder
// character codes, frame geometry, command record and queue status
// ----------------------------------------------------------------------------

package pttd_pkg;

  // parser phases
  typedef enum logic [1:0] {
    PH_MODE   = 2'd0,
    PH_AXIS   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // ascii codes of the command grammar
  localparam logic [7:0] CH_PIXEL = 8'h70;  // 'p'
  localparam logic [7:0] CH_FIXED = 8'h66;  // 'f'
  localparam logic [7:0] CH_PAN   = 8'h70;  // 'p'
  localparam logic [7:0] CH_TILT  = 8'h74;  // 't'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam int NUM_W = 14;
  localparam int POS_W = 11;

  localparam logic [1:0] LAST_DIGIT = 2'd3;

  // camera geometry
  localparam int ANGLE_PAN     = 70;
  localparam int ANGLE_TILT    = 30;
  localparam int FRAME_PAN     = 1920;
  localparam int FRAME_TILT    = 1080;
  localparam int TICKS_PER_DEG = 3;
  localparam int CENTRE_PAN    = 960;
  localparam int CENTRE_TILT   = 540;

  localparam logic [POS_W-1:0] MIN_CHANGE_RESET = 11'd9;

  // pixel offset to ticks: floor(x * SCALE >> SCALE_SHIFT) == floor(x * deg * angle / frame)
  localparam int SCALE_SHIFT = 20;
  localparam int PAN_SCALE =
    (TICKS_PER_DEG * ANGLE_PAN * (1 << SCALE_SHIFT) + FRAME_PAN - 1) / FRAME_PAN;
  localparam int TILT_SCALE =
    (TICKS_PER_DEG * ANGLE_TILT * (1 << SCALE_SHIFT) + FRAME_TILT - 1) / FRAME_TILT;
  localparam int SCALE_W = 17;

  // bound above the largest scaled pixel offset on either axis
  localparam int PIXEL_MAG_BOUND = 128;
  localparam int MAG_W = 7;

  // command queue between parser and goal pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic             mode_pixel;
    logic             axis_tilt;
    logic [NUM_W-1:0] number;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

`default_nettype wire

### src/pttd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pttd_front - command parser
// walks the mode / axis / four digit grammar and issues one command per number
// ----------------------------------------------------------------------------

module pttd_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [7:0]                  rx_byte,
  input  wire logic [pttd_pkg::POS_W-1:0]  pan_position,
  input  wire logic [pttd_pkg::POS_W-1:0]  tilt_position,
  output logic                             cmd_push,
  output pttd_pkg::cmd_t                   cmd
);

  pttd_pkg::phase_t            phase, phase_next;
  logic                        mode_pixel, mode_pixel_next;
  logic                        axis_tilt, axis_tilt_next;
  logic [1:0]                  digit_count, digit_count_next;
  logic [pttd_pkg::NUM_W-1:0]  number_accum, number_accum_next;

  logic                        is_digit;
  logic [7:0]                  digit_byte;
  logic [pttd_pkg::NUM_W-1:0]  accum_mac;

  assign is_digit   = (rx_byte >= pttd_pkg::CH_ZERO) && (rx_byte <= pttd_pkg::CH_NINE);
  assign digit_byte = rx_byte - pttd_pkg::CH_ZERO;
  assign accum_mac  = 14'(number_accum * 14'd10) + {10'd0, digit_byte[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= pttd_pkg::PH_MODE;
      mode_pixel   <= 1'b1;
      axis_tilt    <= 1'b0;
      digit_count  <= 2'd0;
      number_accum <= '0;
    end else begin
      phase        <= phase_next;
      mode_pixel   <= mode_pixel_next;
      axis_tilt    <= axis_tilt_next;
      digit_count  <= digit_count_next;
      number_accum <= number_accum_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    mode_pixel_next   = mode_pixel;
    axis_tilt_next    = axis_tilt;
    digit_count_next  = digit_count;
    number_accum_next = number_accum;
    cmd_push          = 1'b0;
    if (accept) begin
      unique case (phase)
        pttd_pkg::PH_AXIS: begin
          if (rx_byte == pttd_pkg::CH_PAN || rx_byte == pttd_pkg::CH_TILT) begin
            axis_tilt_next    = (rx_byte == pttd_pkg::CH_TILT);
            number_accum_next = '0;
            phase_next        = pttd_pkg::PH_DIGITS;
          end
        end
        pttd_pkg::PH_DIGITS: begin
          if (is_digit) begin
            number_accum_next = accum_mac;
            if (digit_count != pttd_pkg::LAST_DIGIT) begin
              digit_count_next = digit_count + 2'd1;
            end else begin
              phase_next = pttd_pkg::PH_MODE;
              cmd_push   = 1'b1;
            end
          end
        end
        default: begin
          // waiting for a mode letter
          if (rx_byte == pttd_pkg::CH_PIXEL || rx_byte == pttd_pkg::CH_FIXED) begin
            mode_pixel_next  = (rx_byte == pttd_pkg::CH_PIXEL);
            digit_count_next = 2'd0;
            phase_next       = pttd_pkg::PH_AXIS;
          end
        end
      endcase
    end
  end

  assign cmd.mode_pixel = mode_pixel;
  assign cmd.axis_tilt  = axis_tilt;
  assign cmd.number     = accum_mac;
  assign cmd.position   = axis_tilt ? tilt_position : pan_position;

endmodule

`default_nettype wire

### src/pttd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pttd_queue - short command queue
// decouples the parser from the goal pipeline
// ----------------------------------------------------------------------------

module pttd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire pttd_pkg::cmd_t    din,
  input  wire logic              pop,
  output pttd_pkg::cmd_t         dout,
  output pttd_pkg::queue_status_t status
);

  localparam int CNT_W = pttd_pkg::QPTR_W + 1;

  pttd_pkg::cmd_t                entries [pttd_pkg::QUEUE_DEPTH];
  logic [pttd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pttd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]              count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + (pttd_pkg::QPTR_W)'(1);
      if (pop)  rd_ptr <= rd_ptr + (pttd_pkg::QPTR_W)'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

  assign dout         = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(pttd_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

### src/pttd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pttd_back - goal pipeline
// pixel scaling, wrap into one turn, change filter and result register
// ----------------------------------------------------------------------------

module pttd_back #(
  parameter int TICKS_PER_TURN = 1080
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pttd_pkg::cmd_t              cmd,
  input  wire logic                        cmd_valid,
  output logic                             cmd_pop,
  input  wire logic [pttd_pkg::POS_W-1:0]  min_change,
  input  wire logic                        res_ready,
  output logic                             res_valid,
  output logic                             res_axis,
  output logic [pttd_pkg::POS_W-1:0]       res_goal
);

  localparam int NW = pttd_pkg::NUM_W;
  localparam int PW = pttd_pkg::POS_W;
  // whole turns added so that a negative pixel offset stays positive
  localparam int OFFSET =
    ((pttd_pkg::PIXEL_MAG_BOUND + TICKS_PER_TURN - 1) / TICKS_PER_TURN) * TICKS_PER_TURN;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP = (1 << RECIP_SHIFT) / TICKS_PER_TURN;
  localparam int PROD_W = NW + RECIP_SHIFT;
  localparam int QT_W = NW + PW;
  localparam logic [PW-1:0] TICKS = PW'(TICKS_PER_TURN);

  logic adv;

  // stage 0: clamp, centre, scale, add position
  logic [PW-1:0]                    frame, centre, clamped, mag_in;
  logic                             neg;
  logic [pttd_pkg::SCALE_W-1:0]     scale_sel;
  logic [PW+pttd_pkg::SCALE_W-1:0]  scale_prod;
  logic [pttd_pkg::MAG_W-1:0]       mag;
  logic [NW-1:0]                    base, pix_val, pre_val;

  assign frame  = cmd.axis_tilt ? PW'(pttd_pkg::FRAME_TILT) : PW'(pttd_pkg::FRAME_PAN);
  assign centre = cmd.axis_tilt ? PW'(pttd_pkg::CENTRE_TILT) : PW'(pttd_pkg::CENTRE_PAN);
  assign clamped = (cmd.number > {3'd0, frame}) ? frame : cmd.number[PW-1:0];
  assign neg     = (clamped < centre);
  assign mag_in  = neg ? (centre - clamped) : (clamped - centre);
  assign scale_sel = cmd.axis_tilt ? pttd_pkg::SCALE_W'(pttd_pkg::TILT_SCALE)
                                   : pttd_pkg::SCALE_W'(pttd_pkg::PAN_SCALE);
  assign scale_prod = (PW+pttd_pkg::SCALE_W)'(mag_in) * (PW+pttd_pkg::SCALE_W)'(scale_sel);
  assign mag     = scale_prod[pttd_pkg::SCALE_SHIFT +: pttd_pkg::MAG_W];
  assign base    = NW'(cmd.position) + NW'(OFFSET);
  assign pix_val = neg ? (base - NW'(mag)) : (base + NW'(mag));
  assign pre_val = cmd.mode_pixel ? pix_val : cmd.number;

  // stage 1: quotient estimate by reciprocal
  logic          s1_valid, s1_axis;
  logic [NW-1:0] s1_val;
  logic [PROD_W-1:0] q_prod;
  logic [NW-1:0] q_est;

  assign q_prod = PROD_W'(s1_val) * PROD_W'(RECIP);
  assign q_est  = q_prod[RECIP_SHIFT +: NW];

  // stage 2: remainder with one correction
  logic          s2_valid, s2_axis;
  logic [NW-1:0] s2_val, s2_q;
  logic [QT_W-1:0] qt;
  logic [NW-1:0] rem, rem_fix;

  assign qt      = QT_W'(s2_q) * QT_W'(TICKS);
  assign rem     = s2_val - qt[NW-1:0];
  assign rem_fix = (rem >= NW'(TICKS)) ? (rem - NW'(TICKS)) : rem;

  // stage 3: change filter against the stored goal
  logic          s3_valid, s3_axis;
  logic [PW-1:0] s3_goal;
  logic [PW-1:0] pan_goal, tilt_goal, old_goal, diff;
  logic          take;

  assign old_goal = s3_axis ? tilt_goal : pan_goal;
  assign diff     = (old_goal > s3_goal) ? (old_goal - s3_goal) : (s3_goal - old_goal);
  assign take     = s3_valid && (diff >= min_change);

  assign adv     = !res_valid || res_ready;
  assign cmd_pop = adv && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
      pan_goal  <= '0;
      tilt_goal <= '0;
    end else if (adv) begin
      s1_valid  <= cmd_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      res_valid <= take;
      if (take) begin
        if (s3_axis) tilt_goal <= s3_goal;
        else         pan_goal  <= s3_goal;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_val   <= pre_val;
      s1_axis  <= cmd.axis_tilt;
      s2_val   <= s1_val;
      s2_q     <= q_est;
      s2_axis  <= s1_axis;
      s3_goal  <= rem_fix[PW-1:0];
      s3_axis  <= s2_axis;
      res_goal <= s3_goal;
      res_axis <= s3_axis;
    end
  end

endmodule

`default_nettype wire

### src/pan_tilt_command_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pan_tilt_command_decoder - ascii pan/tilt command decoder
// turns received command characters into new pan or tilt goal positions
// ----------------------------------------------------------------------------
// usage
//   s_*   : one received character per item, with the current pan and tilt
//           positions sampled alongside it
//   m_*   : one item per accepted command whose goal moved by at least
//           min_change ticks; m_tuser says which axis, m_tdata the goal
//   cfg_* : write of min_change, always ready, to be used while idle
// throughput: one character per cycle while the command queue has room
// path: the command completed by the last digit passes through the queue, the
//   quotient estimate, remainder, change filter and output register
// stall: a stalled receiver freezes the goal pipeline; the parser keeps taking
//   characters until the four-entry command queue fills, then s_tready drops
// reset: parser waits for a mode letter in pixel mode, both stored goals are
//   zero, min_change returns to 9, the queue and pipeline are emptied
// ----------------------------------------------------------------------------

module pan_tilt_command_decoder #(
  parameter int TICKS_PER_TURN = 1080
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // rx_byte[7:0], pan_position[18:8], tilt_position[29:19]
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // goal_position[10:0]
  output logic [0:0]       m_tuser,   // axis[0]: 0 pan, 1 tilt
  // min_change register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);

  logic                           s_accept;
  logic                           cmd_push;
  logic                           cmd_pop;
  pttd_pkg::cmd_t                 cmd_in;
  pttd_pkg::cmd_t                 cmd_head;
  pttd_pkg::queue_status_t        q_stat;
  logic [pttd_pkg::POS_W-1:0]     min_change;
  logic                           res_axis;
  logic [pttd_pkg::POS_W-1:0]     res_goal;

  // the parser only stalls when the queue has no room
  assign s_tready = !q_stat.full;
  assign s_accept = s_tvalid && s_tready;

  // configuration register, written at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_change <= pttd_pkg::MIN_CHANGE_RESET;
    end else if (cfg_valid) begin
      min_change <= cfg_data;
    end
  end

  // front: grammar walk, one command per completed number
  pttd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (s_accept),
    .rx_byte       (s_tdata[7:0]),
    .pan_position  (s_tdata[18:8]),
    .tilt_position (s_tdata[29:19]),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  // queue between the two halves
  pttd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .din    (cmd_in),
    .pop    (cmd_pop),
    .dout   (cmd_head),
    .status (q_stat)
  );

  // back: goal computation, filter and output register
  pttd_back #(
    .TICKS_PER_TURN (TICKS_PER_TURN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_head),
    .cmd_valid  (!q_stat.empty),
    .cmd_pop    (cmd_pop),
    .min_change (min_change),
    .res_ready  (m_tready),
    .res_valid  (m_tvalid),
    .res_axis   (res_axis),
    .res_goal   (res_goal)
  );

  assign m_tdata = {5'd0, res_goal};
  assign m_tuser = res_axis;

  // a command is never pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(cmd_push && q_stat.full))
    else $error("command pushed into full queue");

  // a waiting command always moves on when the pipeline is free
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && (!m_tvalid || m_tready)) |-> cmd_pop)
    else $error("queued command not taken by free pipeline");

  // every issued goal lies within one turn
  a_goal_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10:0] < 11'(TICKS_PER_TURN)))
    else $error("goal outside one turn");

endmodule

`default_nettype wire
